@@ rtl/elft_pkg.sv @@
// shared types, widths and constants of the element local frame transform
// used by elft_unit and element_local_frame_transform; no dependencies
`timescale 1ns / 1ps

package elft_pkg;

	localparam int unsigned MAX_NODES_DEF = 9;
	localparam int unsigned CW    = 32;
	localparam int unsigned DW    = 33;
	localparam int unsigned PW    = 66;
	localparam int unsigned AW    = 68;
	localparam int unsigned VW    = 64;
	localparam int unsigned NN_W  = 4;
	localparam int unsigned FRAC  = 30;

	// build steps of the frame
	localparam logic [1:0] BS_E1 = 2'd0;
	localparam logic [1:0] BS_E2 = 2'd1;
	localparam logic [1:0] BS_Z  = 2'd2;
	localparam logic [1:0] BS_Y  = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE, ST_PREP, ST_USTART, ST_UNIT, ST_CROSS, ST_XLOAD, ST_XFORM, ST_EMIT
	} elft_state_t;

	typedef enum logic [2:0] {
		U_IDLE, U_SHIFT, U_SQ, U_SQRT, U_DIVLD, U_DIV, U_DONE
	} elft_ustate_t;

	typedef struct packed {
		logic done;
		logic ok;
	} elft_ustat_t;

	typedef struct packed {
		logic [1:0] a;
		logic [1:0] b;
	} elft_xsel_t;

	// component pair of one cross product term, swapped for the subtracted term
	function automatic elft_xsel_t cross_sel(input logic [1:0] comp, input logic swap);
		elft_xsel_t s;
		unique case (comp)
			2'd0:    s = '{a: 2'd1, b: 2'd2};
			2'd1:    s = '{a: 2'd2, b: 2'd0};
			default: s = '{a: 2'd0, b: 2'd1};
		endcase
		if (swap) begin
			s = '{a: s.b, b: s.a};
		end
		return s;
	endfunction

endpackage

@@ rtl/elft_unit.sv @@
// iterative vector normalizer: shift, sum of squares, square root, three divisions
// depends on elft_pkg
`timescale 1ns / 1ps

module elft_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic signed [elft_pkg::VW-1:0]    vec [3],
	output elft_pkg::elft_ustat_t             stat,
	output logic signed [elft_pkg::CW-1:0]    unit [3]
);
	import elft_pkg::*;

	elft_ustate_t us_q, us_d;

	logic [VW-1:0]         m_q [3];
	logic [2:0]            neg_q;
	logic                  ok_q;
	logic [5:0]            cnt_q;
	logic [1:0]            idx_q;
	logic [2*FRAC-1:0]     prod_q;
	logic [VW-1:0]         ss_q;
	logic [VW-1:0]         sx_q;
	logic [VW-1:0]         sr_q;
	logic [VW-1:0]         sb_q;
	logic [CW-1:0]         rem_q;
	logic [CW-1:0]         lo_q;
	logic [CW-1:0]         quo_q;
	logic signed [CW-1:0]  u_q [3];

	logic [VW-1:0]         mag [3];
	logic                  zero;
	logic                  hi_any;
	logic                  lo_all;
	logic [FRAC-1:0]       sq_m;
	logic [VW-1:0]         sq_sum;
	logic [FRAC:0]         n;
	logic [FRAC-1:0]       dv_m;
	logic [2*FRAC:0]       num;
	logic [CW-1:0]         dv_t;
	logic                  dv_ge;
	logic [CW-1:0]         quo_n;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag[i] = vec[i][VW-1] ? (VW'(0) - vec[i]) : vec[i];
		end
		zero   = (vec[0] == '0) && (vec[1] == '0) && (vec[2] == '0);
		hi_any = (m_q[0][VW-1:FRAC] != '0) || (m_q[1][VW-1:FRAC] != '0)
			|| (m_q[2][VW-1:FRAC] != '0);
		lo_all = (m_q[0][VW-1:FRAC-1] == '0) && (m_q[1][VW-1:FRAC-1] == '0)
			&& (m_q[2][VW-1:FRAC-1] == '0);
		unique case (cnt_q[1:0])
			2'd0:    sq_m = m_q[0][FRAC-1:0];
			2'd1:    sq_m = m_q[1][FRAC-1:0];
			default: sq_m = m_q[2][FRAC-1:0];
		endcase
		sq_sum = sr_q + sb_q;
		n      = sr_q[FRAC:0];
		unique case (idx_q)
			2'd0:    dv_m = m_q[0][FRAC-1:0];
			2'd1:    dv_m = m_q[1][FRAC-1:0];
			default: dv_m = m_q[2][FRAC-1:0];
		endcase
		num   = {1'b0, dv_m, {FRAC{1'b0}}} + (2*FRAC+1)'(n[FRAC:1]);
		dv_t  = {rem_q[CW-2:0], lo_q[CW-1]};
		dv_ge = dv_t >= {1'b0, n};
		quo_n = {quo_q[CW-2:0], dv_ge};
	end

	always_comb begin
		us_d = us_q;
		unique case (us_q)
			U_IDLE: begin
				if (start) begin
					us_d = zero ? U_DONE : U_SHIFT;
				end
			end
			U_SHIFT: begin
				if (!hi_any && !lo_all) begin
					us_d = U_SQ;
				end
			end
			U_SQ: begin
				if (cnt_q == 6'd3) begin
					us_d = U_SQRT;
				end
			end
			U_SQRT: begin
				if (cnt_q == 6'd31) begin
					us_d = U_DIVLD;
				end
			end
			U_DIVLD: us_d = U_DIV;
			U_DIV: begin
				if (cnt_q == 6'd31) begin
					us_d = (idx_q == 2'd2) ? U_DONE : U_DIVLD;
				end
			end
			U_DONE:  us_d = U_IDLE;
			default: us_d = U_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			us_q <= U_IDLE;
		end else begin
			us_q <= us_d;
		end
	end

	always_ff @(posedge clk) begin
		unique case (us_q)
			U_IDLE: begin
				if (start) begin
					for (int i = 0; i < 3; i++) begin
						m_q[i]   <= mag[i];
						neg_q[i] <= vec[i][VW-1];
					end
					ok_q  <= !zero;
					cnt_q <= '0;
					idx_q <= '0;
					ss_q  <= '0;
				end
			end
			U_SHIFT: begin
				if (hi_any) begin
					for (int i = 0; i < 3; i++) m_q[i] <= m_q[i] >> 1;
				end else if (lo_all) begin
					for (int i = 0; i < 3; i++) m_q[i] <= m_q[i] << 1;
				end
			end
			U_SQ: begin
				prod_q <= sq_m * sq_m;
				if (cnt_q != 6'd0) begin
					ss_q <= ss_q + VW'(prod_q);
				end
				if (cnt_q == 6'd3) begin
					sx_q  <= ss_q + VW'(prod_q);
					sr_q  <= '0;
					sb_q  <= VW'(1) << (VW - 2);
					cnt_q <= '0;
				end else begin
					cnt_q <= cnt_q + 6'd1;
				end
			end
			U_SQRT: begin
				if (sx_q >= sq_sum) begin
					sx_q <= sx_q - sq_sum;
					sr_q <= (sr_q >> 1) + sb_q;
				end else begin
					sr_q <= sr_q >> 1;
				end
				sb_q  <= sb_q >> 2;
				cnt_q <= (cnt_q == 6'd31) ? 6'd0 : cnt_q + 6'd1;
			end
			U_DIVLD: begin
				rem_q <= CW'(num[2*FRAC:CW]);
				lo_q  <= num[CW-1:0];
				quo_q <= '0;
				cnt_q <= '0;
			end
			U_DIV: begin
				rem_q <= dv_ge ? (dv_t - {1'b0, n}) : dv_t;
				lo_q  <= lo_q << 1;
				quo_q <= quo_n;
				if (cnt_q == 6'd31) begin
					u_q[idx_q] <= neg_q[idx_q] ? (CW'(0) - quo_n) : quo_n;
					idx_q      <= idx_q + 2'd1;
					cnt_q      <= '0;
				end else begin
					cnt_q <= cnt_q + 6'd1;
				end
			end
			default: begin
			end
		endcase
	end

	assign stat.done = (us_q == U_DONE);
	assign stat.ok   = ok_q;
	assign unit      = u_q;

endmodule

@@ rtl/element_local_frame_transform.sv @@
// top level: node buffering, frame build sequencer, shared multiply-accumulate, result register
// depends on elft_pkg and elft_unit
`timescale 1ns / 1ps

// Nodes of a planar element arrive one per transfer, first_node marking node 0.
// Nodes 0 and 1 are stored and give no result. Node 2 starts the frame build:
// four passes through the normalize unit (shift steps, 4 square steps, 32
// square root steps and three divisions each) plus two cross products on the
// shared 33x33 multiplier, then three transforms; node 2 yields three results,
// and a zero-length vector ends the build early. Every later node takes nine
// products through the same multiplier and yields one result. node_stall is
// high while an item is in work; a finished result waits in the output
// register. Nodes past MAX_NODES are dropped without a result.
module element_local_frame_transform #(
	parameter int unsigned MAX_NODES = elft_pkg::MAX_NODES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                node_valid,
	output logic                                node_stall,
	input  logic                                first_node,
	input  logic signed [elft_pkg::CW-1:0]      coord_x,
	input  logic signed [elft_pkg::CW-1:0]      coord_y,
	input  logic signed [elft_pkg::CW-1:0]      coord_z,
	output logic                                result_valid,
	input  logic                                result_stall,
	output logic signed [elft_pkg::CW-1:0]      local_x,
	output logic signed [elft_pkg::CW-1:0]      local_y,
	output logic signed [elft_pkg::CW-1:0]      local_z,
	output logic signed [elft_pkg::CW-1:0]      normal_x,
	output logic signed [elft_pkg::CW-1:0]      normal_y,
	output logic signed [elft_pkg::CW-1:0]      normal_z,
	output logic [elft_pkg::NN_W-1:0]           node_number,
	output logic                                degenerate,
	output logic                                last_of_run
);
	import elft_pkg::*;

	localparam int unsigned CNT_W = $clog2(MAX_NODES + 1);
	localparam int unsigned RW    = AW - FRAC;

	elft_state_t state_q, state_d;

	logic [CNT_W-1:0]       cnt_q;
	logic                   deg_q;
	logic signed [CW-1:0]   hn_q  [3][3];
	logic signed [CW-1:0]   col_q [3][3];
	logic signed [CW-1:0]   cur_q [3];
	logic signed [VW-1:0]   vec_q [3];
	logic signed [CW-1:0]   res_q [3];
	logic [1:0]             bstep_q;
	logic [1:0]             ecnt_q;
	logic                   build_q;
	logic [NN_W-1:0]        idx_q;
	logic [1:0]             jq_q;
	logic [1:0]             kq_q;
	logic                   phase_q;
	logic signed [PW-1:0]   prod_q;
	logic signed [AW-1:0]   acc_q;
	logic                   rv_q;

	logic                   accept;
	logic [CNT_W-1:0]       idx_in;
	logic                   ignore;
	logic                   out_free;
	logic [1:0]             hsel;
	logic signed [DW-1:0]   dprep [3];
	logic signed [DW-1:0]   dcur  [3];
	logic [1:0]             ca;
	logic [1:0]             cb;
	elft_xsel_t             xs;
	logic signed [DW-1:0]   mul_a;
	logic signed [DW-1:0]   mul_b;
	logic signed [AW-1:0]   prod_x;
	logic signed [AW-1:0]   acc_n;
	logic                   ustart;
	elft_ustat_t            ustat;
	logic signed [CW-1:0]   u [3];
	logic [1:0]             dest;

	function automatic logic signed [CW-1:0] round_sat(input logic signed [AW-1:0] v);
		logic signed [AW-1:0] s;
		logic signed [RW-1:0] t;
		s = v + (AW'(1) <<< (FRAC - 1));
		t = s[AW-1:FRAC];
		if (t > RW'(32'sh7FFF_FFFF)) begin
			return 32'sh7FFF_FFFF;
		end else if (t < -(RW'(1) <<< (CW - 1))) begin
			return 32'sh8000_0000;
		end
		return t[CW-1:0];
	endfunction

	elft_unit u_unit (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ustart),
		.vec    (vec_q),
		.stat   (ustat),
		.unit   (u)
	);

	always_comb begin
		node_stall = (state_q != ST_IDLE);
		accept     = node_valid && !node_stall;
		idx_in     = first_node ? '0 : cnt_q;
		ignore     = idx_in >= CNT_W'(MAX_NODES);
		out_free   = !rv_q || !result_stall;
		ustart     = (state_q == ST_USTART);
		hsel       = (state_q == ST_PREP) ? (bstep_q + 2'd1) : ecnt_q;
		for (int k = 0; k < 3; k++) begin
			dprep[k] = {hn_q[hsel][k][CW-1], hn_q[hsel][k]} - {hn_q[0][k][CW-1], hn_q[0][k]};
			dcur[k]  = {cur_q[k][CW-1], cur_q[k]} - {hn_q[0][k][CW-1], hn_q[0][k]};
		end
		ca = (bstep_q == BS_Z) ? 2'd0 : 2'd2;
		cb = (bstep_q == BS_Z) ? 2'd1 : 2'd0;
		xs = cross_sel(jq_q, kq_q[0]);
		if (state_q == ST_CROSS) begin
			mul_a = {col_q[ca][xs.a][CW-1], col_q[ca][xs.a]};
			mul_b = {col_q[cb][xs.b][CW-1], col_q[cb][xs.b]};
		end else begin
			mul_a = {col_q[jq_q][kq_q][CW-1], col_q[jq_q][kq_q]};
			mul_b = dcur[kq_q];
		end
		prod_x = {{(AW - PW){prod_q[PW-1]}}, prod_q};
		if ((state_q == ST_CROSS) && kq_q[0]) begin
			acc_n = acc_q - prod_x;
		end else begin
			acc_n = acc_q + prod_x;
		end
		unique case (bstep_q)
			BS_E1:   dest = 2'd0;
			BS_E2:   dest = 2'd1;
			BS_Z:    dest = 2'd2;
			default: dest = 2'd1;
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && !ignore) begin
					if (idx_in == CNT_W'(2)) begin
						state_d = ST_PREP;
					end else if (idx_in > CNT_W'(2)) begin
						state_d = ST_XFORM;
					end
				end
			end
			ST_PREP:   state_d = (bstep_q == BS_E1 || bstep_q == BS_E2) ? ST_USTART : ST_CROSS;
			ST_USTART: state_d = ST_UNIT;
			ST_UNIT: begin
				if (ustat.done) begin
					state_d = (!ustat.ok || bstep_q == BS_Y) ? ST_XLOAD : ST_PREP;
				end
			end
			ST_CROSS: begin
				if (phase_q && jq_q == 2'd2 && kq_q == 2'd1) begin
					state_d = ST_USTART;
				end
			end
			ST_XLOAD: state_d = ST_XFORM;
			ST_XFORM: begin
				if (phase_q && jq_q == 2'd2 && kq_q == 2'd2) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					state_d = (build_q && ecnt_q != 2'd2) ? ST_XLOAD : ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			deg_q   <= 1'b0;
			rv_q    <= 1'b0;
			for (int j = 0; j < 3; j++) begin
				for (int k = 0; k < 3; k++) col_q[j][k] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (accept) begin
				cnt_q <= ignore ? CNT_W'(MAX_NODES) : idx_in + CNT_W'(1);
			end
			if (state_q == ST_UNIT && ustat.done) begin
				if (!ustat.ok) begin
					deg_q <= 1'b1;
					for (int j = 0; j < 3; j++) begin
						for (int k = 0; k < 3; k++) col_q[j][k] <= '0;
					end
				end else begin
					for (int k = 0; k < 3; k++) col_q[dest][k] <= u[k];
					if (bstep_q == BS_Y) begin
						deg_q <= 1'b0;
					end
				end
			end
			if (state_q == ST_EMIT && out_free) begin
				rv_q <= 1'b1;
			end else if (!result_stall) begin
				rv_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept && !ignore) begin
					if (idx_in < CNT_W'(3)) begin
						hn_q[idx_in[1:0]][0] <= coord_x;
						hn_q[idx_in[1:0]][1] <= coord_y;
						hn_q[idx_in[1:0]][2] <= coord_z;
					end
					cur_q[0] <= coord_x;
					cur_q[1] <= coord_y;
					cur_q[2] <= coord_z;
					idx_q    <= NN_W'(idx_in);
					build_q  <= (idx_in == CNT_W'(2));
					bstep_q  <= BS_E1;
					ecnt_q   <= '0;
					jq_q     <= '0;
					kq_q     <= '0;
					phase_q  <= 1'b0;
					acc_q    <= '0;
				end
			end
			ST_PREP: begin
				if (bstep_q == BS_E1 || bstep_q == BS_E2) begin
					for (int k = 0; k < 3; k++) begin
						vec_q[k] <= {{(VW - DW){dprep[k][DW-1]}}, dprep[k]};
					end
				end
				jq_q    <= '0;
				kq_q    <= '0;
				phase_q <= 1'b0;
				acc_q   <= '0;
			end
			ST_UNIT: begin
				if (ustat.done) begin
					bstep_q <= bstep_q + 2'd1;
				end
			end
			ST_CROSS: begin
				if (!phase_q) begin
					prod_q  <= mul_a * mul_b;
					phase_q <= 1'b1;
				end else begin
					phase_q <= 1'b0;
					if (kq_q == 2'd1) begin
						vec_q[jq_q] <= acc_n[VW-1:0];
						acc_q       <= '0;
						kq_q        <= '0;
						jq_q        <= jq_q + 2'd1;
					end else begin
						acc_q <= acc_n;
						kq_q  <= 2'd1;
					end
				end
			end
			ST_XLOAD: begin
				for (int k = 0; k < 3; k++) cur_q[k] <= hn_q[hsel][k];
				idx_q   <= NN_W'(ecnt_q);
				jq_q    <= '0;
				kq_q    <= '0;
				phase_q <= 1'b0;
				acc_q   <= '0;
			end
			ST_XFORM: begin
				if (!phase_q) begin
					prod_q  <= mul_a * mul_b;
					phase_q <= 1'b1;
				end else begin
					phase_q <= 1'b0;
					if (kq_q == 2'd2) begin
						res_q[jq_q] <= round_sat(acc_n);
						acc_q       <= '0;
						kq_q        <= '0;
						jq_q        <= jq_q + 2'd1;
					end else begin
						acc_q <= acc_n;
						kq_q  <= kq_q + 2'd1;
					end
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					local_x     <= res_q[0];
					local_y     <= res_q[1];
					local_z     <= res_q[2];
					normal_x    <= col_q[2][0];
					normal_y    <= col_q[2][1];
					normal_z    <= col_q[2][2];
					node_number <= idx_q;
					degenerate  <= deg_q;
					last_of_run <= !build_q || (ecnt_q == 2'd2);
					ecnt_q      <= ecnt_q + 2'd1;
				end
			end
			default: begin
			end
		endcase
	end

	assign result_valid = rv_q;

endmodule

@@ rtl/elft_check.sv @@
// port-level checks of element_local_frame_transform and the bind that attaches them
// depends on element_local_frame_transform
`timescale 1ns / 1ps

module elft_check (
	input logic               clk,
	input logic               arst_n,
	input logic               result_valid,
	input logic               result_stall,
	input logic signed [31:0] local_x,
	input logic signed [31:0] local_y,
	input logic signed [31:0] local_z,
	input logic signed [31:0] normal_x,
	input logic signed [31:0] normal_y,
	input logic signed [31:0] normal_z,
	input logic [3:0]         node_number,
	input logic               degenerate,
	input logic               last_of_run
);

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(local_x)
		&& $stable(local_y) && $stable(local_z) && $stable(node_number)
		&& $stable(last_of_run))
	else $error("stalled result changed");

	// degenerate element gives zero coordinates and zero normal
	a_degen: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && degenerate |-> local_x == 0 && local_y == 0 && local_z == 0
		&& normal_x == 0 && normal_y == 0 && normal_z == 0)
	else $error("degenerate result not zero");

	// node 0 sits at the origin of its frame
	a_origin: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && node_number == 4'd0 |-> local_x == 0 && local_y == 0 && local_z == 0)
	else $error("node 0 not at origin");

	// nodes 0 and 1 come before node 2 in one run, later nodes close their own run
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (last_of_run == (node_number >= 4'd2)))
	else $error("last_of_run wrong for node");

endmodule

bind element_local_frame_transform elft_check u_elft_check (.*);

@@ verif/tb.sv @@
// testbench of element_local_frame_transform: streams element nodes, predicts the
// local frame results in a scoreboard class and checks every result transfer
// depends on elft_pkg and the rtl of element_local_frame_transform
`timescale 1ns / 1ps

typedef struct {
	logic signed [31:0] lx, ly, lz, nx, ny, nz;
	logic [3:0]         nn;
	logic               deg, last;
} frame_result_t;

class frame_scoreboard;
	longint        held[9];
	longint        frame[9];
	int unsigned   node_cnt;
	bit            deg_flag;
	frame_result_t awaited[$];
	int            errors;

	function new();
		foreach (held[i]) held[i] = 0;
		foreach (frame[i]) frame[i] = 0;
		node_cnt = 0;
		deg_flag = 0;
		errors = 0;
	endfunction

	function int pending();
		return awaited.size();
	endfunction

	function longint unsigned int_sqrt(longint unsigned x);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function bit unit_vec(input longint c[3], output longint u[3]);
		longint unsigned m[3], top, ss, n, q;
		bit neg[3];
		top = 0;
		for (int i = 0; i < 3; i++) begin
			neg[i] = c[i] < 0;
			m[i] = neg[i] ? longint'(-c[i]) : c[i];
			if (m[i] > top) top = m[i];
		end
		if (top == 0) return 0;
		while (top >= (64'd1 << 30)) begin
			top >>= 1;
			for (int i = 0; i < 3; i++) m[i] >>= 1;
		end
		while (top < (64'd1 << 29)) begin
			top <<= 1;
			for (int i = 0; i < 3; i++) m[i] <<= 1;
		end
		ss = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
		n = int_sqrt(ss);
		for (int i = 0; i < 3; i++) begin
			q = ((m[i] << 30) + n / 2) / n;
			u[i] = neg[i] ? -longint'(q) : longint'(q);
		end
		return 1;
	endfunction

	function void cross3(input longint a[3], input longint b[3], output longint r[3]);
		r[0] = a[1] * b[2] - a[2] * b[1];
		r[1] = a[2] * b[0] - a[0] * b[2];
		r[2] = a[0] * b[1] - a[1] * b[0];
	endfunction

	function void build_frame();
		longint d1[3], d2[3], e1[3], e2[3], c[3], ex[3], ey[3], ez[3];
		bit ok;
		for (int k = 0; k < 3; k++) begin
			d1[k] = held[3 + k] - held[k];
			d2[k] = held[6 + k] - held[k];
		end
		ok = unit_vec(d1, e1);
		if (ok) ok = unit_vec(d2, e2);
		if (ok) begin
			ex = e1;
			cross3(e1, e2, c);
			ok = unit_vec(c, ez);
		end
		if (ok) begin
			cross3(ez, ex, c);
			ok = unit_vec(c, ey);
		end
		if (!ok) begin
			foreach (frame[i]) frame[i] = 0;
			deg_flag = 1;
			return;
		end
		for (int k = 0; k < 3; k++) begin
			frame[k * 3 + 0] = ex[k];
			frame[k * 3 + 1] = ey[k];
			frame[k * 3 + 2] = ez[k];
		end
		deg_flag = 0;
	endfunction

	function logic signed [31:0] project(input longint d[3], input int axis);
		longint p, sq, sr, t;
		sq = 0;
		sr = 0;
		for (int k = 0; k < 3; k++) begin
			p = frame[k * 3 + axis] * d[k];
			sq += p >>> 30;
			sr += p & 64'h3FFF_FFFF;
		end
		t = sq + (sr + (64'd1 << 29)) / (64'd1 << 30);
		if (t > 64'sd2147483647) t = 64'sd2147483647;
		if (t < -64'sd2147483648) t = -64'sd2147483648;
		return t[31:0];
	endfunction

	function void push_local(input longint g[3], input int unsigned idx, input bit last);
		longint d[3];
		frame_result_t r;
		for (int j = 0; j < 3; j++) d[j] = g[j] - held[j];
		r.lx = project(d, 0);
		r.ly = project(d, 1);
		r.lz = project(d, 2);
		r.nx = frame[2][31:0];
		r.ny = frame[5][31:0];
		r.nz = frame[8][31:0];
		r.nn = idx[3:0];
		r.deg = deg_flag;
		r.last = last;
		awaited.push_back(r);
	endfunction

	function void note_node(bit first, logic signed [31:0] x, y, z);
		longint g[3], h[3];
		int unsigned idx;
		idx = first ? 0 : node_cnt;
		g[0] = x;
		g[1] = y;
		g[2] = z;
		if (idx >= 9) begin
			node_cnt = 9;
			return;
		end
		node_cnt = idx + 1;
		if (idx < 3) for (int k = 0; k < 3; k++) held[idx * 3 + k] = g[k];
		if (idx < 2) return;
		if (idx == 2) begin
			build_frame();
			for (int n = 0; n < 3; n++) begin
				for (int k = 0; k < 3; k++) h[k] = held[n * 3 + k];
				push_local(h, n, n == 2);
			end
			return;
		end
		push_local(g, idx, 1);
	endfunction

	function void check_result(frame_result_t a);
		frame_result_t e;
		if (awaited.size() == 0) begin
			errors++;
			if (errors <= 10) $display("unexpected result transfer node %0d", a.nn);
			return;
		end
		e = awaited.pop_front();
		if (a.lx !== e.lx || a.ly !== e.ly || a.lz !== e.lz || a.nx !== e.nx
				|| a.ny !== e.ny || a.nz !== e.nz || a.nn !== e.nn
				|| a.deg !== e.deg || a.last !== e.last) begin
			errors++;
			if (errors <= 10) begin
				$display("mismatch exp l=%0d %0d %0d n=%0d %0d %0d nn=%0d dg=%0d lst=%0d",
					e.lx, e.ly, e.lz, e.nx, e.ny, e.nz, e.nn, e.deg, e.last);
				$display("         got l=%0d %0d %0d n=%0d %0d %0d nn=%0d dg=%0d lst=%0d",
					a.lx, a.ly, a.lz, a.nx, a.ny, a.nz, a.nn, a.deg, a.last);
			end
		end
	endfunction
endclass

module tb;
	import elft_pkg::*;

	logic clk = 0;
	logic arst_n = 0;
	logic node_valid = 0;
	logic node_stall;
	logic first_node = 0;
	logic signed [31:0] coord_x = 0, coord_y = 0, coord_z = 0;
	logic result_valid;
	logic result_stall = 0;
	logic signed [31:0] local_x, local_y, local_z, normal_x, normal_y, normal_z;
	logic [3:0] node_number;
	logic degenerate, last_of_run;

	frame_scoreboard sb = new();
	bit quiet = 0;
	int items = 0;

	element_local_frame_transform DUT (.*);

	always #5 clk = ~clk;

	initial begin
		#5ms;
		$display("TEST FAILED");
		$finish;
	end

	always @(posedge clk) begin
		frame_result_t r;
		if (arst_n && result_valid && !result_stall) begin
			r.lx = local_x;
			r.ly = local_y;
			r.lz = local_z;
			r.nx = normal_x;
			r.ny = normal_y;
			r.nz = normal_z;
			r.nn = node_number;
			r.deg = degenerate;
			r.last = last_of_run;
			sb.check_result(r);
		end
		result_stall <= !quiet && ($urandom_range(0, 99) < 11);
	end

	task automatic send_node(bit first, logic signed [31:0] x, y, z);
		while (!quiet && $urandom_range(0, 99) < 11) begin
			node_valid <= 0;
			@(posedge clk);
		end
		node_valid <= 1;
		first_node <= first;
		coord_x <= x;
		coord_y <= y;
		coord_z <= z;
		@(posedge clk);
		while (node_stall) @(posedge clk);
		sb.note_node(first, x, y, z);
		items++;
	endtask

	function automatic logic signed [31:0] rand_coord(bit wide);
		if (wide) return $urandom;
		return $signed($urandom_range(0, 4000000)) - 2000000;
	endfunction

	// mode: 0 normal, 1 node1 on node0, 2 node2 on node0, 3 collinear
	task automatic send_element(int n, int mode, bit wide, bit flag);
		logic signed [31:0] p0[3], p1[3], c[3];
		for (int k = 0; k < 3; k++) begin
			p0[k] = rand_coord(wide);
			p1[k] = rand_coord(wide);
		end
		if (mode == 3) for (int k = 0; k < 3; k++) p0[k] = rand_coord(0);
		if (mode == 3) for (int k = 0; k < 3; k++) p1[k] = rand_coord(0);
		if (mode == 1) p1 = p0;
		send_node(flag, p0[0], p0[1], p0[2]);
		send_node(0, p1[0], p1[1], p1[2]);
		for (int i = 2; i < n; i++) begin
			for (int k = 0; k < 3; k++) c[k] = rand_coord(wide);
			if (i == 2 && mode == 2) c = p0;
			if (i == 2 && mode == 3)
				for (int k = 0; k < 3; k++) c[k] = p0[k] + 3 * (p1[k] - p0[k]);
			send_node(0, c[0], c[1], c[2]);
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// stream with no first_node after reset
		send_node(0, 32'sh0001_0000, 0, 0);
		send_node(0, 32'sh0003_0000, 32'sh0000_8000, 0);
		send_node(0, 32'sh0001_0000, 32'sh0002_0000, 32'sh0000_4000);
		send_node(0, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff);
		// extreme coordinates
		send_node(1, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
		send_node(0, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000);
		send_node(0, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff);
		send_node(0, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff);
		send_element(3, 1, 0, 1);
		send_element(4, 2, 0, 1);
		send_element(3, 3, 0, 1);
		send_element(12, 0, 1, 1);
		node_valid <= 0;
		while (sb.pending() != 0) @(posedge clk);
		send_element(3, 0, 0, 1);
		while (items < 95) begin
			quiet = (items > 50 && items < 75);
			if ($urandom_range(0, 9) == 0)
				send_node($urandom_range(0, 1), $urandom, $urandom, $urandom);
			else
				send_element($urandom_range(0, 4) == 0 ? $urandom_range(3, 11)
					: $urandom_range(3, 5), $urandom_range(0, 7) == 0
					? $urandom_range(1, 3) : 0, $urandom_range(0, 1), 1);
		end
		quiet = 0;
		node_valid <= 0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (1000) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end
endmodule
